// ===== rtl/core/lfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared types and constants for the lowest free slot allocator: event and
// result beats, status codes, action codes and the classified operation
// codes that pass from the front to the back.
// ----------------------------------------------------------------------------
package lfsa_pkg;

   localparam int SLOTS_DEFAULT      = 256;
   localparam int REQUESTERS_DEFAULT = 256;

   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOT_HELD = 2'd2;

   typedef enum logic [2:0] {
      OP_ALLOC_NEW,
      OP_ALLOC_HELD,
      OP_RELEASE,
      OP_REJECT_FULL,
      OP_REJECT_NOT_HELD
   } op_type;

   typedef struct packed {
      logic       action;
      logic [7:0] requester_id;
   } req_type;

   typedef struct packed {
      logic [7:0] slot;
      logic [1:0] status;
      logic [8:0] occupied;
      logic [8:0] peak_occupied;
   } rsp_type;

endpackage

// ===== rtl/core/lfsa_fifo.sv =====
// ----------------------------------------------------------------------------
// lfsa_fifo
// Small first-in first-out queue with registered storage, used between the
// front and the back and as the result queue.
// ----------------------------------------------------------------------------
module lfsa_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty,
   output logic             full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(DEPTH));
   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;
   assign head_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/lfsa_front.sv =====
// ----------------------------------------------------------------------------
// lfsa_front
// Accepts event beats, looks up the holder table for the requester and
// classifies the event into one operation for the back.
// ----------------------------------------------------------------------------
module lfsa_front #(
   parameter int SLOTS      = lfsa_pkg::SLOTS_DEFAULT,
   parameter int REQUESTERS = lfsa_pkg::REQUESTERS_DEFAULT,
   localparam int SW = $clog2(SLOTS),
   localparam int IW = $clog2(REQUESTERS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  lfsa_pkg::req_type req_data,
   output logic             req_full,
   input  logic             mid_empty,
   output logic             mid_push,
   output lfsa_pkg::op_type mid_op,
   output logic [IW-1:0]    mid_idx,
   output logic [SW-1:0]    mid_slot,
   input  logic             wr_en,
   input  logic [IW-1:0]    wr_addr,
   input  logic             wr_valid,
   input  logic [SW-1:0]    wr_slot
);

   import lfsa_pkg::*;

   logic [SW-1:0] holder_mem [REQUESTERS];
   logic          valid_ff [REQUESTERS];
   logic          pend_ff, pend_in;
   logic          act_ff;
   logic [7:0]    id_ff;
   logic [SW-1:0] rd_slot_ff;
   logic          rd_valid_ff;
   logic [IW-1:0] rd_addr;
   logic          accept;
   logic          in_range;

   assign req_full = pend_ff | ~mid_empty;
   assign accept   = req_push & ~req_full;
   assign rd_addr  = IW'(req_data.requester_id);
   assign pend_in  = accept;
   assign in_range = (32'(id_ff) < REQUESTERS);

   assign mid_push = pend_ff;
   assign mid_idx  = IW'(id_ff);
   assign mid_slot = rd_slot_ff;

   always_comb begin
      if (act_ff == ACT_ALLOC) begin
         if (!in_range) begin
            mid_op = OP_REJECT_FULL;
         end else if (rd_valid_ff) begin
            mid_op = OP_ALLOC_HELD;
         end else begin
            mid_op = OP_ALLOC_NEW;
         end
      end else begin
         if (in_range && rd_valid_ff) begin
            mid_op = OP_RELEASE;
         end else begin
            mid_op = OP_REJECT_NOT_HELD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         for (int i = 0; i < REQUESTERS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         pend_ff <= pend_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= wr_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff      <= req_data.action;
         id_ff       <= req_data.requester_id;
         rd_slot_ff  <= holder_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (wr_en) begin
         holder_mem[wr_addr] <= wr_slot;
      end
   end

endmodule

// ===== rtl/core/lfsa_back.sv =====
// ----------------------------------------------------------------------------
// lfsa_back
// Carries out classified operations: finds the lowest free slot, updates the
// free map, occupancy and peak, writes the holder table and builds results.
// ----------------------------------------------------------------------------
module lfsa_back #(
   parameter int SLOTS      = lfsa_pkg::SLOTS_DEFAULT,
   parameter int REQUESTERS = lfsa_pkg::REQUESTERS_DEFAULT,
   localparam int SW = $clog2(SLOTS),
   localparam int IW = $clog2(REQUESTERS),
   localparam int CW = $clog2(SLOTS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             mid_empty,
   input  lfsa_pkg::op_type mid_op,
   input  logic [IW-1:0]    mid_idx,
   input  logic [SW-1:0]    mid_slot,
   output logic             mid_pop,
   output logic             wr_en,
   output logic [IW-1:0]    wr_addr,
   output logic             wr_valid,
   output logic [SW-1:0]    wr_slot,
   input  logic             out_full,
   output logic             out_push,
   output lfsa_pkg::rsp_type out_data
);

   import lfsa_pkg::*;

   logic [SLOTS-1:0] free_ff, free_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    peak_ff, peak_in;
   logic             go;
   logic             found;
   logic [SW-1:0]    first_idx;
   logic [SW-1:0]    slot;
   logic [1:0]       status;

   assign go       = ~mid_empty & ~out_full;
   assign mid_pop  = go;
   assign out_push = go;
   assign wr_addr  = mid_idx;

   always_comb begin
      found     = 1'b0;
      first_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            found     = 1'b1;
            first_idx = SW'(i);
         end
      end
   end

   always_comb begin
      free_in  = free_ff;
      count_in = count_ff;
      slot     = '0;
      status   = ST_OK;
      wr_en    = 1'b0;
      wr_valid = 1'b0;
      wr_slot  = '0;
      case (mid_op)
         OP_ALLOC_NEW: begin
            if (found) begin
               free_in[first_idx] = 1'b0;
               count_in           = count_ff + 1'b1;
               wr_en              = go;
               wr_valid           = 1'b1;
               wr_slot            = first_idx;
               slot               = first_idx;
            end else begin
               status = ST_FULL;
            end
         end
         OP_ALLOC_HELD: begin
            slot = mid_slot;
         end
         OP_RELEASE: begin
            if (!free_ff[mid_slot]) begin
               free_in[mid_slot] = 1'b1;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
            end
            wr_en = go;
            slot  = mid_slot;
         end
         OP_REJECT_FULL: begin
            status = ST_FULL;
         end
         OP_REJECT_NOT_HELD: begin
            status = ST_NOT_HELD;
         end
         default: begin
            status = ST_NOT_HELD;
         end
      endcase
      peak_in = (count_in > peak_ff) ? count_in : peak_ff;
   end

   always_comb begin
      out_data.slot          = 8'(slot);
      out_data.status        = status;
      out_data.occupied      = 9'(count_in);
      out_data.peak_occupied = 9'(peak_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff  <= '1;
         count_ff <= '0;
         peak_ff  <= '0;
      end else if (go) begin
         free_ff  <= free_in;
         count_ff <= count_in;
         peak_ff  <= peak_in;
      end
   end

endmodule

// ===== rtl/core/lowest_free_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_top
// Find-first-free slot allocator driven by arrive and leave events.
//
// Event queue side: drive req_data and raise req_push; a beat is taken at a
// rising edge with req_push high and req_full low. Result queue side: while
// rsp_empty is low the oldest result sits on rsp_data; raise rsp_pop to take
// it. Each event yields exactly one result: slot, status, occupancy and peak.
//
// The front reads the holder table into its registers, the operation passes
// through the middle queue, and the back commits the free map and holder
// table as it pushes the result into the result queue. A new event is taken
// only once that commit is done, so one event is through before the next.
//
// Reset: every slot is free, no requester holds a slot, occupancy and peak
// are zero; the holder valid bits clear in the reset cycle itself.
// Stall: when the consumer holds rsp_pop low the result queue fills, the back
// holds its operation, and req_full stays high until space opens.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator_top #(
   parameter int SLOTS      = lfsa_pkg::SLOTS_DEFAULT,
   parameter int REQUESTERS = lfsa_pkg::REQUESTERS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  lfsa_pkg::req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output lfsa_pkg::rsp_type rsp_data
);

   import lfsa_pkg::*;

   localparam int SW  = $clog2(SLOTS);
   localparam int IW  = $clog2(REQUESTERS);
   localparam int OPW = $bits(op_type);
   localparam int MW  = OPW + IW + SW;
   localparam int RW  = $bits(rsp_type);

   logic          mid_push, mid_pop, mid_empty, mid_full;
   op_type        f_op, b_op;
   logic [IW-1:0] f_idx, b_idx;
   logic [SW-1:0] f_slot, b_slot;
   logic [MW-1:0] mid_in, mid_head;
   logic          wr_en, wr_valid;
   logic [IW-1:0] wr_addr;
   logic [SW-1:0] wr_slot;
   logic          out_push, out_full;
   rsp_type       out_data;
   logic [RW-1:0] rsp_bits;

   assign mid_in = {f_op, f_idx, f_slot};
   assign b_op   = op_type'(mid_head[MW-1 -: OPW]);
   assign b_idx  = mid_head[SW +: IW];
   assign b_slot = mid_head[SW-1:0];

   lfsa_front #(
      .SLOTS      (SLOTS),
      .REQUESTERS (REQUESTERS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .mid_empty (mid_empty),
      .mid_push  (mid_push),
      .mid_op    (f_op),
      .mid_idx   (f_idx),
      .mid_slot  (f_slot),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_valid  (wr_valid),
      .wr_slot   (wr_slot)
   );

   lfsa_fifo #(
      .WIDTH (MW),
      .DEPTH (2)
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in),
      .pop       (mid_pop),
      .head_data (mid_head),
      .empty     (mid_empty),
      .full      (mid_full)
   );

   lfsa_back #(
      .SLOTS      (SLOTS),
      .REQUESTERS (REQUESTERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty | mid_full & 1'b0),
      .mid_op    (b_op),
      .mid_idx   (b_idx),
      .mid_slot  (b_slot),
      .mid_pop   (mid_pop),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_valid  (wr_valid),
      .wr_slot   (wr_slot),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   lfsa_fifo #(
      .WIDTH (RW),
      .DEPTH (2)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .pop       (rsp_pop),
      .head_data (rsp_bits),
      .empty     (rsp_empty),
      .full      (out_full)
   );

   assign rsp_data = rsp_type'(rsp_bits);

endmodule

// ===== dv/lowest_free_slot_allocator_top_test.sv =====
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_top_test
// Self-checking bench for the lowest free slot allocator. A driver pushes
// arrive and leave beats from a backlog. A shadow allocator predicts one
// result per accepted beat. A monitor pops results under random stalls and
// compares every field against the oldest prediction. Stimulus runs a short
// directed set, then fills the pool to capacity, drains it to empty, and
// finishes with biased random phases plus noise.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lfsa_pkg::*;

   localparam int SLOTS         = 256;
   localparam int REQUESTERS    = 256;
   localparam int RANDOM_EVENTS = 950;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   req_type queued_events[$];
   rsp_type awaited_results[$];

   logic [SLOTS-1:0]      slot_free = '1;
   bit   [REQUESTERS-1:0] id_holds = '0;
   logic [7:0]            id_slot [REQUESTERS];
   int                    occupancy = 0;
   int                    peak_occupancy = 0;

   bit [REQUESTERS-1:0] plan_holds = '0;
   int planned = 0;

   int push_hold = 0;
   int push_calm = 0;
   int pop_hold = 0;
   int pop_calm = 0;
   int cycle_count = 0;
   int errors = 0;
   int events_taken = 0;
   int results_ok = 0;
   int results_full = 0;
   int results_not_held = 0;
   int top_occupancy = 0;

   lowest_free_slot_allocator_top #(
      .SLOTS(SLOTS),
      .REQUESTERS(REQUESTERS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_data(req_data),
      .req_full(req_full),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   function automatic rsp_type predict_outcome(req_type ev);
      rsp_type r;
      int      s;
      int      i;
      r.slot = '0;
      r.status = ST_OK;
      if (ev.action == ACT_ALLOC) begin
         if (int'(ev.requester_id) >= REQUESTERS) begin
            r.status = ST_FULL;
         end else if (id_holds[ev.requester_id]) begin
            r.slot = id_slot[ev.requester_id];
         end else begin
            s = -1;
            for (i = SLOTS - 1; i >= 0; i--)
               if (slot_free[i]) s = i;
            if (s < 0) begin
               r.status = ST_FULL;
            end else begin
               slot_free[s] = 1'b0;
               id_holds[ev.requester_id] = 1'b1;
               id_slot[ev.requester_id] = s[7:0];
               occupancy++;
               r.slot = s[7:0];
            end
         end
      end else begin
         if (int'(ev.requester_id) >= REQUESTERS || !id_holds[ev.requester_id]) begin
            r.status = ST_NOT_HELD;
         end else begin
            s = id_slot[ev.requester_id];
            if (!slot_free[s]) begin
               slot_free[s] = 1'b1;
               if (occupancy > 0) occupancy--;
            end
            id_holds[ev.requester_id] = 1'b0;
            r.slot = s[7:0];
         end
      end
      if (occupancy > peak_occupancy) peak_occupancy = occupancy;
      r.occupied = occupancy[8:0];
      r.peak_occupied = peak_occupancy[8:0];
      return r;
   endfunction

   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_id(bit want_held);
      int tries;
      int start;
      int k;
      logic [7:0] id;
      for (tries = 0; tries < 16; tries++) begin
         id = 8'($urandom_range(0, REQUESTERS - 1));
         if (plan_holds[id] == want_held) return id;
      end
      start = $urandom_range(0, REQUESTERS - 1);
      for (k = 0; k < REQUESTERS; k++) begin
         id = 8'((start + k) % REQUESTERS);
         if (plan_holds[id] == want_held) return id;
      end
      return 8'($urandom_range(0, REQUESTERS - 1));
   endfunction

   task automatic add_event(logic action, logic [7:0] id);
      req_type ev;
      ev.action = action;
      ev.requester_id = id;
      queued_events = {queued_events, ev};
      plan_holds[id] = (action == ACT_ALLOC);
      planned++;
   endtask

   task automatic add_noise();
      add_event(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_quiet();
      while (queued_events.size() != 0 || req_push || awaited_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_push && !req_full) begin
            awaited_results = {awaited_results, predict_outcome(req_data)};
            events_taken++;
         end
         if (!req_push || !req_full) begin
            if (push_hold > 0) begin
               push_hold--;
               req_push <= 1'b0;
            end else if (queued_events.size() > 0) begin
               req_data <= queued_events.pop_front();
               req_push <= 1'b1;
               push_hold = pick_gap(push_calm);
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual %p",
                        $time, rsp_data);
               errors++;
            end else begin
               want = awaited_results.pop_front();
               check_field("slot", want.slot, rsp_data.slot);
               check_field("status", want.status, rsp_data.status);
               check_field("occupied", want.occupied, rsp_data.occupied);
               check_field("peak_occupied", want.peak_occupied, rsp_data.peak_occupied);
               case (want.status)
                  ST_OK:       results_ok++;
                  ST_FULL:     results_full++;
                  ST_NOT_HELD: results_not_held++;
                  default:     ;
               endcase
               if (int'(want.occupied) > top_occupancy) top_occupancy = int'(want.occupied);
            end
            pop_hold = pick_gap(pop_calm);
         end
         if (pop_hold > 0) begin
            pop_hold--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  awaited_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int phase_kind;
      int phase_len;
      int n;
      int roll;
      int goal;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_event(ACT_RELEASE, 8'h00);
      add_event(ACT_ALLOC,   8'h00);
      add_event(ACT_ALLOC,   8'hFF);
      add_event(ACT_ALLOC,   8'h00);
      add_event(ACT_ALLOC,   8'h80);
      add_event(ACT_RELEASE, 8'h00);
      add_event(ACT_RELEASE, 8'h00);
      add_event(ACT_ALLOC,   8'h55);
      add_event(ACT_ALLOC,   8'hAA);
      add_event(ACT_RELEASE, 8'hFF);
      add_event(ACT_RELEASE, 8'h7F);
      add_event(ACT_ALLOC,   8'h01);
      add_event(ACT_ALLOC,   8'hFE);
      add_event(ACT_RELEASE, 8'h80);
      add_event(ACT_ALLOC,   8'h7F);
      add_event(ACT_RELEASE, 8'h55);
      add_event(ACT_RELEASE, 8'h01);
      add_event(ACT_ALLOC,   8'hFF);
      wait_quiet();

      goal = planned + RANDOM_EVENTS;
      while (plan_holds != '1) add_event(ACT_ALLOC, pick_id(1'b0));
      for (n = 0; n < 10; n++) add_event(ACT_ALLOC, 8'($urandom_range(0, 255)));
      wait_quiet();
      while (plan_holds != '0) add_event(ACT_RELEASE, pick_id(1'b1));
      for (n = 0; n < 5; n++) add_event(ACT_RELEASE, 8'($urandom_range(0, 255)));

      while (planned < goal) begin
         phase_kind = $urandom_range(0, 3);
         phase_len = $urandom_range(20, 100);
         for (n = 0; n < phase_len && planned < goal; n++) begin
            roll = $urandom_range(0, 99);
            if (phase_kind == 3 || roll < 10) begin
               add_noise();
            end else if (phase_kind == 0) begin
               if (roll < 85) add_event(ACT_ALLOC, pick_id(1'b0));
               else add_event(ACT_RELEASE, pick_id(1'b1));
            end else if (phase_kind == 1) begin
               if (roll < 85) add_event(ACT_RELEASE, pick_id(1'b1));
               else add_event(ACT_ALLOC, pick_id(1'b0));
            end else begin
               if (roll < 55) add_event(ACT_ALLOC, pick_id(1'b0));
               else add_event(ACT_RELEASE, pick_id(1'b1));
            end
         end
      end

      while (queued_events.size() != 0 || req_push) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d events: %0d ok, %0d pool full, %0d release without holding",
               events_taken, results_ok, results_full, results_not_held);
      $display("Occupancy swept from empty up to %0d of %0d slots and back down",
               top_occupancy, SLOTS);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== lowest_free_slot_allocator_top.f =====
rtl/core/lfsa_pkg.sv
rtl/core/lfsa_fifo.sv
rtl/core/lfsa_front.sv
rtl/core/lfsa_back.sv
rtl/core/lowest_free_slot_allocator_top.sv
dv/lowest_free_slot_allocator_top_test.sv
